// ===== design/icac_pkg.sv =====
// Shared types and constants for the interval capacity admission core.
package icac_pkg;

  // Field widths fixed by the request and result formats
  localparam int STATION_W = 11;
  localparam int LOAD_W    = 16;
  localparam int SUM_W     = LOAD_W + 1;
  localparam int ALU_W     = LOAD_W + 2;
  localparam int CFG_W     = 16;

  // Default route size
  localparam int MAX_STATIONS_DEF = 1024;

  // Register indexes on the configuration port
  localparam logic [0:0] CFG_STATION_COUNT = 1'b0;
  localparam logic [0:0] CFG_SEAT_CAPACITY = 1'b1;

  // Register reset values
  localparam logic [STATION_W-1:0] STATION_COUNT_RST = 11'd1024;
  localparam logic [LOAD_W-1:0]    SEAT_CAPACITY_RST = 16'hFFFF;

  // Request beat
  typedef struct packed {
    logic [STATION_W-1:0] from_station;
    logic [STATION_W-1:0] to_station;
    logic [LOAD_W-1:0]    head_count;
  } req_t;

  // Result beat
  typedef struct packed {
    logic              accepted;
    logic [LOAD_W-1:0] peak_load;
  } rsp_t;

  // Clipped segment range of a request
  typedef struct packed {
    logic [STATION_W-1:0] lo;
    logic [STATION_W-1:0] hi;
    logic                 empty;
  } clip_t;

endpackage

// ===== design/icac_clip.sv =====
// Clips a request's station pair to the valid segment range of the route.
module icac_clip #(
  parameter int MAX_STATIONS = icac_pkg::MAX_STATIONS_DEF
) (
  input  logic [icac_pkg::STATION_W-1:0] from_station,
  input  logic [icac_pkg::STATION_W-1:0] to_station,
  input  logic [icac_pkg::STATION_W-1:0] station_count,
  output icac_pkg::clip_t                clip
);
  import icac_pkg::*;

  logic [STATION_W-1:0] n_sat;
  logic [STATION_W-1:0] lo;
  logic [STATION_W-1:0] hi;

  // Station count saturated to the store depth
  assign n_sat = (32'(station_count) > MAX_STATIONS) ? STATION_W'(MAX_STATIONS)
                                                      : station_count;

  // Segment range lo..hi, clipped to 1..n-1
  always_comb begin
    lo = (from_station == '0) ? STATION_W'(1) : from_station;
    hi = (to_station == '0) ? '0 : to_station - STATION_W'(1);
    if (n_sat < STATION_W'(2)) begin
      hi = '0;
    end else if (hi > n_sat - STATION_W'(1)) begin
      hi = n_sat - STATION_W'(1);
    end
  end

  assign clip.lo    = lo;
  assign clip.hi    = hi;
  assign clip.empty = (lo > hi);

endmodule

// ===== design/icac_alu.sv =====
// Shared add/subtract unit used for peak compare, capacity check and load update.
module icac_alu (
  input  logic [icac_pkg::SUM_W-1:0] a,
  input  logic [icac_pkg::SUM_W-1:0] b,
  input  logic                       sub,
  output logic [icac_pkg::ALU_W-1:0] res
);
  import icac_pkg::*;

  logic [ALU_W-1:0] b_ext;

  // a + b, or a - b in two's complement; res msb set means a < b when subtracting
  assign b_ext = sub ? ~{1'b0, b} : {1'b0, b};
  assign res   = {1'b0, a} + b_ext + ALU_W'(sub);

endmodule

// ===== design/icac_engine.sv =====
// Sequencer and segment load store: clears, scans for peak, checks and updates.
module icac_engine #(
  parameter int MAX_STATIONS = icac_pkg::MAX_STATIONS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  icac_pkg::req_t              request,
  input  icac_pkg::clip_t             clip,
  input  logic [icac_pkg::LOAD_W-1:0] seat_capacity,
  output logic                        busy,
  output logic                        done,
  output icac_pkg::rsp_t              result
);
  import icac_pkg::*;

  localparam int AW = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_STATIONS - 1);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_SUM    = 6'b001000,
    ST_CMP    = 6'b010000,
    ST_UPDATE = 6'b100000
  } state_t;

  state_t               state;
  logic [STATION_W-1:0] cur;
  logic [STATION_W-1:0] lo;
  logic [STATION_W-1:0] hi;
  logic                 empty;
  logic [LOAD_W-1:0]    need;
  logic [LOAD_W-1:0]    peak;
  logic [SUM_W-1:0]     sum;
  logic [AW-1:0]        clr_addr;

  logic [LOAD_W-1:0]    mem [MAX_STATIONS];
  logic [LOAD_W-1:0]    rdata;
  logic [AW-1:0]        raddr;
  logic [AW-1:0]        waddr;
  logic [LOAD_W-1:0]    wdata;
  logic                 we;

  logic [SUM_W-1:0]     alu_a;
  logic [SUM_W-1:0]     alu_b;
  logic                 alu_sub;
  logic [ALU_W-1:0]     alu_res;

  // Segment s lives at store index s-1
  function automatic logic [AW-1:0] seg_addr(input logic [STATION_W-1:0] s);
    logic [STATION_W-1:0] idx;
    idx = s - STATION_W'(1);
    return AW'(idx);
  endfunction

  // Load store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Read address: prefetch the segment needed next cycle
  always_comb begin
    unique case (state)
      ST_IDLE:   raddr = seg_addr(clip.lo);
      ST_SCAN:   raddr = seg_addr(cur + STATION_W'(1));
      ST_CMP:    raddr = seg_addr(lo);
      ST_UPDATE: raddr = seg_addr(cur + STATION_W'(1));
      default:   raddr = seg_addr(cur);
    endcase
  end

  // Write port: clearing pass or load update
  always_comb begin
    we    = 1'b0;
    waddr = clr_addr;
    wdata = '0;
    unique case (state)
      ST_CLEAR: begin
        we = 1'b1;
      end
      ST_UPDATE: begin
        we    = 1'b1;
        waddr = seg_addr(cur);
        wdata = alu_res[LOAD_W-1:0];
      end
      default: ;
    endcase
  end

  // Operand select for the shared unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state)
      ST_SCAN: begin
        alu_a   = {1'b0, peak};
        alu_b   = {1'b0, rdata};
        alu_sub = 1'b1;
      end
      ST_SUM: begin
        alu_a = {1'b0, peak};
        alu_b = {1'b0, need};
      end
      ST_CMP: begin
        alu_a   = {1'b0, seat_capacity};
        alu_b   = sum;
        alu_sub = 1'b1;
      end
      ST_UPDATE: begin
        alu_a = {1'b0, rdata};
        alu_b = {1'b0, need};
      end
      default: ;
    endcase
  end

  icac_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            need  <= request.head_count;
            cur   <= clip.lo;
            lo    <= clip.lo;
            hi    <= clip.hi;
            empty <= clip.empty;
            peak  <= '0;
            state <= clip.empty ? ST_SUM : ST_SCAN;
          end
        end
        ST_SCAN: begin
          // peak < load read back: take the new maximum
          if (alu_res[ALU_W-1]) begin
            peak <= rdata;
          end
          if (cur == hi) begin
            state <= ST_SUM;
          end else begin
            cur <= cur + STATION_W'(1);
          end
        end
        ST_SUM: begin
          sum   <= alu_res[SUM_W-1:0];
          state <= ST_CMP;
        end
        ST_CMP: begin
          result.accepted  <= ~alu_res[ALU_W-1];
          result.peak_load <= peak;
          if (!alu_res[ALU_W-1] && !empty) begin
            cur   <= lo;
            state <= ST_UPDATE;
          end else begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        ST_UPDATE: begin
          if (cur == hi) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            cur <= cur + STATION_W'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

// ===== design/interval_capacity_admission_core.sv =====
// Top level: configuration registers, range clipping and the admission engine.
//
// Seat admission on one route. A request beat is taken at a clock edge with
// start high and busy low. After reset the core sweeps its segment load store
// to zero, one entry a cycle, and holds busy high until the sweep is done. While
// a request is served busy stays high: the load store is walked once over the
// clipped range to find the peak and, if the request is accepted and the range
// is not empty, once more to add the head count. Done is high for exactly one
// cycle, in the cycle busy drops; result then holds the beat until the next
// request's capacity check, and the receiver cannot stall it. Configuration
// writes take effect at once and are meant for idle periods.
module interval_capacity_admission_core #(
  parameter int MAX_STATIONS = icac_pkg::MAX_STATIONS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  icac_pkg::req_t              request,
  output logic                        busy,
  output logic                        done,
  output icac_pkg::rsp_t              result,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [icac_pkg::CFG_W-1:0]  cfg_data
);
  import icac_pkg::*;

  logic [STATION_W-1:0] station_count;
  logic [LOAD_W-1:0]    seat_capacity;
  clip_t                clip;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      station_count <= STATION_COUNT_RST;
      seat_capacity <= SEAT_CAPACITY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STATION_COUNT: station_count <= cfg_data[STATION_W-1:0];
        CFG_SEAT_CAPACITY: seat_capacity <= cfg_data[LOAD_W-1:0];
        default: ;
      endcase
    end
  end

  icac_clip #(
    .MAX_STATIONS (MAX_STATIONS)
  ) u_clip (
    .from_station  (request.from_station),
    .to_station    (request.to_station),
    .station_count (station_count),
    .clip          (clip)
  );

  icac_engine #(
    .MAX_STATIONS (MAX_STATIONS)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .request       (request),
    .clip          (clip),
    .seat_capacity (seat_capacity),
    .busy          (busy),
    .done          (done),
    .result        (result)
  );

endmodule
